// ----- rtl/core/hmq_pkg.sv -----
// Shared types and constants for the heightmap triangle height query block.
`default_nettype none

package hmq_pkg;

  // Configuration register
  localparam int          CFG_W         = 9;
  localparam logic [8:0]  MAP_SIZE_RST  = 9'd256;

  // Input item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Queue depths
  localparam int CMD_DEPTH = 2;   // front -> back command queue
  localparam int OUT_DEPTH = 4;   // result buffer ahead of the out port

  typedef struct packed {
    logic        kind;
    logic [15:0] entry_address;
    logic [7:0]  entry_height;
    logic [15:0] pos_x;
    logic [15:0] pos_depth;
  } in_item_t;

  typedef struct packed {
    logic        in_range;
    logic [15:0] height;
  } out_item_t;

  // Width of one front -> back command: four flags, two weights, two addresses, one byte.
  function automatic int hmq_cmd_w(input int max_map, input int frac);
    return 12 + 2 * (frac + 1) + 2 * $clog2(max_map * max_map);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hmq_fifo.sv -----
// Small register FIFO with valid/ready on both sides.
`default_nettype none

module hmq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign in_ready  = cnt_r != CNT_W'(DEPTH);
  assign out_valid = cnt_r != '0;
  assign out_data  = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hmq_front.sv -----
// Front end: range check, cell lookup, triangle pick and grid address build.
`default_nettype none

module hmq_front import hmq_pkg::*; #(
  parameter int MAX_MAP_SIZE = 256,
  parameter int FRAC_BITS    = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [CFG_W-1:0]     map_size,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output logic [hmq_cmd_w(MAX_MAP_SIZE, FRAC_BITS)-1:0] cmd_data
);

  localparam int IDX_W       = $clog2(MAX_MAP_SIZE);
  localparam int CW          = $clog2(MAX_MAP_SIZE + 1);
  localparam int ADDR_W      = $clog2(MAX_MAP_SIZE * MAX_MAP_SIZE);
  localparam int STORE_DEPTH = MAX_MAP_SIZE * MAX_MAP_SIZE;
  localparam int F_W         = FRAC_BITS + 1;
  localparam logic [F_W-1:0] FX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic              is_query;
    logic              wen;
    logic              in_range;
    logic [IDX_W-1:0]  ix;
    logic [IDX_W-1:0]  iz;
    logic [F_W-1:0]    fx;
    logic [F_W-1:0]    fz;
    logic [CW-1:0]     ms;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } s1_t;

  typedef struct packed {
    logic              is_query;
    logic              wen;
    logic              in_range;
    logic              lower;
    logic [F_W-1:0]    w1;
    logic [F_W-1:0]    w2;
    logic [ADDR_W-1:0] prod;
    logic [IDX_W-1:0]  ix;
    logic [CW-1:0]     ms;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } s2_t;

  typedef struct packed {
    logic              is_query;
    logic              wen;
    logic              in_range;
    logic              lower;
    logic [F_W-1:0]    w1;
    logic [F_W-1:0]    w2;
    logic [ADDR_W-1:0] a_top;
    logic [ADDR_W-1:0] a_bot;
    logic [7:0]        wdata;
  } cmd_t;

  logic        s1_v_r, s1_v_nxt;
  logic        s2_v_r, s2_v_nxt;
  logic        s1_free, s2_free;
  s1_t         s1_r, s1_calc;
  s2_t         s2_r, s2_calc;
  cmd_t        cmd_s;

  logic [CW-1:0] ms_eff;
  logic [31:0]   lim, msm2, px_i, pz_i;
  logic          clamp_x, clamp_z;
  logic [F_W:0]  fsum;

  // stage handshake
  assign s2_free   = !s2_v_r || cmd_ready;
  assign s1_free   = !s1_v_r || s2_free;
  assign in_ready  = s1_free;
  assign cmd_valid = s2_v_r;

  always_comb begin
    s1_v_nxt = s1_free ? in_valid : s1_v_r;
    s2_v_nxt = s2_free ? s1_v_r : s2_v_r;
  end

  // stage 1: classify, range check, clamp to the last cell
  always_comb begin
    ms_eff = (32'(map_size) > 32'(MAX_MAP_SIZE)) ? CW'(MAX_MAP_SIZE) : CW'(map_size);
    lim    = (32'(ms_eff) - 32'd1) << FRAC_BITS;
    msm2   = 32'(ms_eff) - 32'd2;
    px_i   = 32'(in_data.pos_x) >> FRAC_BITS;
    pz_i   = 32'(in_data.pos_depth) >> FRAC_BITS;
    // past ms-2 only on the far edge, where the fraction is a whole tile
    clamp_x = px_i > msm2;
    clamp_z = pz_i > msm2;

    s1_calc.is_query = in_data.kind == KIND_QUERY;
    s1_calc.wen      = 32'(in_data.entry_address) < 32'(STORE_DEPTH);
    s1_calc.in_range = (ms_eff >= CW'(2)) &&
                       (32'(in_data.pos_x) <= lim) && (32'(in_data.pos_depth) <= lim);
    s1_calc.ix       = clamp_x ? IDX_W'(msm2) : IDX_W'(px_i);
    s1_calc.iz       = clamp_z ? IDX_W'(msm2) : IDX_W'(pz_i);
    s1_calc.fx       = clamp_x ? FX_ONE : F_W'(in_data.pos_x[FRAC_BITS-1:0]);
    s1_calc.fz       = clamp_z ? FX_ONE : F_W'(in_data.pos_depth[FRAC_BITS-1:0]);
    s1_calc.ms       = ms_eff;
    s1_calc.addr     = ADDR_W'(in_data.entry_address);
    s1_calc.wdata    = in_data.entry_height;
  end

  // stage 2: triangle pick, corner weights, row base
  always_comb begin
    fsum = {1'b0, s1_r.fx} + {1'b0, s1_r.fz};
    s2_calc.is_query = s1_r.is_query;
    s2_calc.wen      = s1_r.wen;
    s2_calc.in_range = s1_r.in_range;
    s2_calc.lower    = fsum < {1'b0, FX_ONE};
    // lower-left half is anchored at h0, the other half at h3
    s2_calc.w1       = s2_calc.lower ? s1_r.fx : FX_ONE - s1_r.fz;
    s2_calc.w2       = s2_calc.lower ? s1_r.fz : FX_ONE - s1_r.fx;
    s2_calc.prod     = ADDR_W'(s1_r.iz) * ADDR_W'(s1_r.ms);
    s2_calc.ix       = s1_r.ix;
    s2_calc.ms       = s1_r.ms;
    s2_calc.addr     = s1_r.addr;
    s2_calc.wdata    = s1_r.wdata;
  end

  // command out: top-row and bottom-row corner addresses
  always_comb begin
    cmd_s.is_query = s2_r.is_query;
    cmd_s.wen      = s2_r.wen;
    cmd_s.in_range = s2_r.in_range;
    cmd_s.lower    = s2_r.lower;
    cmd_s.w1       = s2_r.w1;
    cmd_s.w2       = s2_r.w2;
    cmd_s.a_top    = s2_r.is_query ? s2_r.prod + ADDR_W'(s2_r.ix) : s2_r.addr;
    cmd_s.a_bot    = s2_r.prod + ADDR_W'(s2_r.ix) + ADDR_W'(s2_r.ms);
    cmd_s.wdata    = s2_r.wdata;
  end

  assign cmd_data = cmd_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_r <= s1_calc;
    end
    if (s2_free) begin
      s2_r <= s2_calc;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hmq_back.sv -----
// Back end: height store, three-read sequencer and interpolation datapath.
`default_nettype none

module hmq_back import hmq_pkg::*; #(
  parameter int MAX_MAP_SIZE = 256,
  parameter int FRAC_BITS    = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  logic [hmq_cmd_w(MAX_MAP_SIZE, FRAC_BITS)-1:0] cmd_data,
  output logic      res_valid,
  input  logic      res_room,
  output out_item_t res_data,
  input  logic      res_release
);

  localparam int ADDR_W      = $clog2(MAX_MAP_SIZE * MAX_MAP_SIZE);
  localparam int STORE_DEPTH = MAX_MAP_SIZE * MAX_MAP_SIZE;
  localparam int F_W         = FRAC_BITS + 1;
  localparam int PW          = FRAC_BITS + 11;   // signed diff times weight
  localparam int VW          = FRAC_BITS + 12;   // sum of three terms
  localparam int VM          = FRAC_BITS + 8;    // magnitude of a valid height
  localparam int CR_W        = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic              is_query;
    logic              wen;
    logic              in_range;
    logic              lower;
    logic [F_W-1:0]    w1;
    logic [F_W-1:0]    w2;
    logic [ADDR_W-1:0] a_top;
    logic [ADDR_W-1:0] a_bot;
    logic [7:0]        wdata;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD2  = 3'b010,
    ST_RD3  = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_H1,
    TAG_H2,
    TAG_FIN
  } tag_kind_t;

  typedef struct packed {
    tag_kind_t      kind;
    logic           in_range;
    logic [F_W-1:0] w1;
    logic [F_W-1:0] w2;
  } tag_t;

  cmd_t              head, cur_r;
  state_t            state_r, state_nxt;
  tag_t              tag_r, tag_nxt;
  logic [CR_W-1:0]   credit_r, credit_nxt;
  logic              credit_ok, reserve, load_cur;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        store_mem [STORE_DEPTH];
  logic [7:0]        rdata_r;
  logic [7:0]        h1_r, h2_r;

  logic              m1_v_r, m1_v_nxt;
  logic              m1_inr_r;
  logic [7:0]        m1_base_r;
  logic signed [PW-1:0] m1_p1_r, m1_p2_r;
  logic signed [8:0]    d1, d2;
  logic signed [PW-1:0] p1, p2;
  logic signed [VW-1:0] base_sc, v;
  logic [VM-1:0]     vpos;
  logic [15:0]       conv;

  assign head      = cmd_t'(cmd_data);
  assign credit_ok = credit_r < CR_W'(OUT_DEPTH);

  // read sequencer: h1, then h2, then the anchor corner (h0 or h3)
  always_comb begin
    state_nxt     = state_r;
    cmd_ready     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = head.a_top;
    reserve       = 1'b0;
    load_cur      = 1'b0;
    tag_nxt.kind     = TAG_NONE;
    tag_nxt.in_range = 1'b0;
    tag_nxt.w1       = cur_r.w1;
    tag_nxt.w2       = cur_r.w2;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (!head.is_query) begin
            cmd_ready = 1'b1;
            mem_we    = head.wen;
          end else if (credit_ok && res_room) begin
            cmd_ready = 1'b1;
            reserve   = 1'b1;
            load_cur  = 1'b1;
            if (head.in_range) begin
              mem_re       = 1'b1;
              mem_addr     = head.a_top + ADDR_W'(1);
              tag_nxt.kind = TAG_H1;
              state_nxt    = ST_RD2;
            end else begin
              // off the map: straight to the result, no reads
              tag_nxt.kind = TAG_FIN;
            end
          end
        end
      end
      ST_RD2: begin
        mem_re       = 1'b1;
        mem_addr     = cur_r.a_bot;
        tag_nxt.kind = TAG_H2;
        state_nxt    = ST_RD3;
      end
      ST_RD3: begin
        mem_re           = 1'b1;
        mem_addr         = cur_r.lower ? cur_r.a_top : cur_r.a_bot + ADDR_W'(1);
        tag_nxt.kind     = TAG_FIN;
        tag_nxt.in_range = 1'b1;
        state_nxt        = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // one result slot held per query from issue until its beat leaves
  always_comb begin
    credit_nxt = credit_r + CR_W'(reserve) - CR_W'(res_release);
    m1_v_nxt   = tag_r.kind == TAG_FIN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tag_r    <= '{kind: TAG_NONE, in_range: 1'b0, w1: '0, w2: '0};
      credit_r <= '0;
      m1_v_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tag_r    <= tag_nxt;
      credit_r <= credit_nxt;
      m1_v_r   <= m1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cur) begin
      cur_r <= head;
    end
  end

  // single-port height store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_addr] <= head.wdata;
    end else if (mem_re) begin
      rdata_r <= store_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tag_r.kind == TAG_H1) begin
      h1_r <= rdata_r;
    end
    if (tag_r.kind == TAG_H2) begin
      h2_r <= rdata_r;
    end
  end

  // stage M1: corner differences times weights; rdata_r holds the anchor
  always_comb begin
    d1 = $signed({1'b0, h1_r}) - $signed({1'b0, rdata_r});
    d2 = $signed({1'b0, h2_r}) - $signed({1'b0, rdata_r});
    p1 = PW'(d1) * PW'($signed({1'b0, tag_r.w1}));
    p2 = PW'(d2) * PW'($signed({1'b0, tag_r.w2}));
  end

  always_ff @(posedge clk) begin
    m1_inr_r  <= tag_r.in_range;
    m1_base_r <= rdata_r;
    m1_p1_r   <= p1;
    m1_p2_r   <= p2;
  end

  // stage M2: sum and scale to 8 fraction bits
  always_comb begin
    base_sc = $signed({{(VW - VM){1'b0}}, m1_base_r, {FRAC_BITS{1'b0}}});
    v       = base_sc + VW'(m1_p1_r) + VW'(m1_p2_r);
    vpos    = v[VW-1] ? '0 : v[VM-1:0];
  end

  generate
    if (FRAC_BITS > 8) begin : g_round
      localparam int SH = FRAC_BITS - 8;
      localparam logic [VM:0] HALF = (VM + 1)'(1) << (SH - 1);
      logic [VM:0] rnd;
      assign rnd  = {1'b0, vpos} + HALF;
      assign conv = 16'(rnd >> SH);
    end else if (FRAC_BITS == 8) begin : g_same
      assign conv = vpos;
    end else begin : g_widen
      assign conv = 16'(vpos) << (8 - FRAC_BITS);
    end
  endgenerate

  assign res_valid         = m1_v_r;
  assign res_data.in_range = m1_inr_r;
  assign res_data.height   = m1_inr_r ? conv : 16'd0;

endmodule

`default_nettype wire

// ----- rtl/core/heightmap_triangle_height_query.sv -----
// Top level of the heightmap triangle height query block.
`default_nettype none

// Holds a square grid of byte heights (map_size points a side, capped at MAX_MAP_SIZE)
// and answers height queries. A load beat (kind 0) writes one byte at row*map_size+col
// and produces no result; loads past the store are dropped. A query beat (kind 1) takes
// pos_x and pos_depth with FRAC_BITS fraction bits, finds the cell (clamped on the far
// edge), splits it on the top-right to bottom-left diagonal, and returns in_range plus
// the height with 8 fraction bits (rounded half up when FRAC_BITS > 8); off-map queries
// return in_range 0 and height 0. The front end classifies each beat in two register
// stages and hands it through a two-entry queue to the back end, which owns a
// single-port height memory. Loads retire one per cycle while the back end is idle; an
// on-map query makes three corner reads of that memory port, and the back end takes no
// new beat until the third read is issued. Off-map queries retire one per cycle while
// a result slot is free. The store is not cleared at reset: querying a cell whose
// corners were never loaded gives an unspecified height. Write map_size only while the
// block is idle.
module heightmap_triangle_height_query import hmq_pkg::*; #(
  parameter int MAX_MAP_SIZE = 256,
  parameter int FRAC_BITS    = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int CMD_W = hmq_cmd_w(MAX_MAP_SIZE, FRAC_BITS);
  localparam int RES_W = $bits(out_item_t);

  logic [CFG_W-1:0] map_size_r, map_size_nxt;

  // front -> queue
  logic             fq_valid, fq_ready;
  logic [CMD_W-1:0] fq_data;
  // queue -> back
  logic             qb_valid, qb_ready;
  logic [CMD_W-1:0] qb_data;
  // back -> result buffer
  logic             res_valid, res_room;
  out_item_t        res_data;
  logic [RES_W-1:0] res_vec, out_vec;
  logic             out_beat;

  // map_size register; reset to the full 256-point map
  assign map_size_nxt = cfg_wr_en ? cfg_wr_data : map_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_size_r <= MAP_SIZE_RST;
    end else begin
      map_size_r <= map_size_nxt;
    end
  end

  hmq_front #(
    .MAX_MAP_SIZE (MAX_MAP_SIZE),
    .FRAC_BITS    (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .map_size  (map_size_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd_data  (fq_data)
  );

  // decouples classification from the memory sequencer
  hmq_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  hmq_back #(
    .MAX_MAP_SIZE (MAX_MAP_SIZE),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (qb_valid),
    .cmd_ready   (qb_ready),
    .cmd_data    (qb_data),
    .res_valid   (res_valid),
    .res_room    (res_room),
    .res_data    (res_data),
    .res_release (out_beat)
  );

  // result buffer: the back end reserves a slot before starting a query,
  // so its datapath never has to stall
  assign res_vec  = res_data;
  assign out_beat = out_valid && out_ready;

  hmq_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (res_valid),
    .in_ready  (res_room),
    .in_data   (res_vec),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_vec)
  );

  assign out_data = out_item_t'(out_vec);

endmodule

`default_nettype wire
